[hw/rtl/bounded_list_deque_with_search_assert.svh]
// Assertion macros shared by the deque RTL.
// BLD_ASSERT is checked outside reset; BLD_ASSERT_RST is also checked across reset.
`ifndef BOUNDED_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define BLD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define BLD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLD_ASSERT(label, clk, rstn, prop, msg)
`define BLD_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

[hw/rtl/bld_pkg.sv]
`default_nettype none

package bld_pkg;

    localparam int CAPACITY     = 64;
    localparam int DATA_WIDTH   = 32;
    localparam int VALUE_W      = 32;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 7;
    localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int IN_FIELDS_W  = KIND_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VALUE_W + 1 + STATUS_W + OCC_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [VALUE_W-1:0]    value_t;
    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [KIND_W-1:0]            kind_code_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = KIND_W'(0),
        KIND_PUSH_BACK  = KIND_W'(1),
        KIND_POP_FRONT  = KIND_W'(2),
        KIND_POP_BACK   = KIND_W'(3),
        KIND_REMOVE     = KIND_W'(4),
        KIND_QUERY      = KIND_W'(5)
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = STATUS_W'(0),
        STAT_EMPTY = STATUS_W'(1),
        STAT_FULL  = STATUS_W'(2)
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_DATA,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // logical index read this cycle
    typedef enum logic [1:0] {
        RD_FRONT,
        RD_BACK,
        RD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    push;
        logic    pop;
        logic    take_pop;
        logic    set_status;
        status_t status;
        logic    set_found;
        logic    scan_init;
        logic    advance;
        logic    shift_wr;
        logic    drop;
        logic    emit;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        kind_code_t kind;
        logic       empty;
        logic       full;
        logic       match;
        logic       at_last;
        logic       out_free;
    } dp_stat_t;

    // (base + off) modulo CAPACITY, with base < CAPACITY and off <= CAPACITY
    function automatic addr_t wrap_add(addr_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return addr_t'(sum);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bld_ctrl.sv]
`default_nettype none

module bld_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire bld_pkg::dp_stat_t stat_i,
    output bld_pkg::dp_cmd_t       cmd_o
);

    bld_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bld_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bld_pkg::S_IDLE: begin
                if (s_tvalid) state_next = bld_pkg::S_EXEC;
            end
            bld_pkg::S_EXEC: begin
                case (stat_i.kind) inside
                    bld_pkg::KIND_POP_FRONT, bld_pkg::KIND_POP_BACK: begin
                        state_next = stat_i.empty ? bld_pkg::S_DONE : bld_pkg::S_POP_DATA;
                    end
                    bld_pkg::KIND_REMOVE, bld_pkg::KIND_QUERY: begin
                        state_next = stat_i.empty ? bld_pkg::S_DONE : bld_pkg::S_SCAN;
                    end
                    default: state_next = bld_pkg::S_DONE;
                endcase
            end
            bld_pkg::S_POP_DATA: state_next = bld_pkg::S_DONE;
            bld_pkg::S_SCAN: begin
                if (stat_i.match) begin
                    if (stat_i.kind == bld_pkg::KIND_REMOVE && !stat_i.at_last) begin
                        state_next = bld_pkg::S_SHIFT;
                    end else begin
                        state_next = bld_pkg::S_DONE;
                    end
                end else if (stat_i.at_last) begin
                    state_next = bld_pkg::S_DONE;
                end
            end
            bld_pkg::S_SHIFT: begin
                if (stat_i.at_last) state_next = bld_pkg::S_DONE;
            end
            bld_pkg::S_DONE: begin
                if (stat_i.out_free) state_next = bld_pkg::S_IDLE;
            end
            default: state_next = bld_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd_o        = '0;
        cmd_o.status = bld_pkg::STAT_OK;
        cmd_o.rd_sel = bld_pkg::RD_NEXT;
        s_tready     = 1'b0;
        unique case (state_reg)
            bld_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd_o.load = s_tvalid;
            end
            bld_pkg::S_EXEC: begin
                case (stat_i.kind) inside
                    bld_pkg::KIND_PUSH_FRONT, bld_pkg::KIND_PUSH_BACK: begin
                        if (stat_i.full) begin
                            cmd_o.set_status = 1'b1;
                            cmd_o.status     = bld_pkg::STAT_FULL;
                        end else begin
                            cmd_o.push = 1'b1;
                        end
                    end
                    bld_pkg::KIND_POP_FRONT, bld_pkg::KIND_POP_BACK: begin
                        if (stat_i.empty) begin
                            cmd_o.set_status = 1'b1;
                            cmd_o.status     = bld_pkg::STAT_EMPTY;
                        end else begin
                            cmd_o.pop    = 1'b1;
                            cmd_o.rd_sel = (stat_i.kind == bld_pkg::KIND_POP_FRONT) ?
                                           bld_pkg::RD_FRONT : bld_pkg::RD_BACK;
                        end
                    end
                    bld_pkg::KIND_REMOVE, bld_pkg::KIND_QUERY: begin
                        cmd_o.rd_sel    = bld_pkg::RD_FRONT;
                        cmd_o.scan_init = !stat_i.empty;
                    end
                    default: ;
                endcase
            end
            bld_pkg::S_POP_DATA: cmd_o.take_pop = 1'b1;
            bld_pkg::S_SCAN: begin
                if (stat_i.match) begin
                    cmd_o.set_found = 1'b1;
                    if (stat_i.kind == bld_pkg::KIND_REMOVE) begin
                        // match on the tail needs no shift
                        cmd_o.drop    = stat_i.at_last;
                        cmd_o.advance = !stat_i.at_last;
                    end
                end else begin
                    cmd_o.advance = !stat_i.at_last;
                end
            end
            bld_pkg::S_SHIFT: begin
                cmd_o.shift_wr = 1'b1;
                cmd_o.drop     = stat_i.at_last;
                cmd_o.advance  = !stat_i.at_last;
            end
            bld_pkg::S_DONE: cmd_o.emit = stat_i.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/bld_datapath.sv]
`default_nettype none

`include "bounded_list_deque_with_search_assert.svh"

module bld_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bld_pkg::dp_cmd_t              cmd_i,
    output bld_pkg::dp_stat_t                  stat_o,
    input  wire logic [bld_pkg::KIND_W-1:0]    in_kind,
    input  wire bld_pkg::value_t               in_value,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output bld_pkg::value_t                    out_popped_value,
    output logic                               out_found,
    output logic [bld_pkg::STATUS_W-1:0]       out_status,
    output logic [bld_pkg::OCC_W-1:0]          out_occupancy
);

    bld_pkg::word_t mem [bld_pkg::CAPACITY];
    bld_pkg::word_t rdata_reg;

    bld_pkg::kind_code_t kind_reg;
    bld_pkg::value_t     value_reg;

    bld_pkg::addr_t head_reg, head_next;
    bld_pkg::cnt_t  count_reg, count_next;
    bld_pkg::cnt_t  cmp_idx_reg, cmp_idx_next;

    bld_pkg::value_t  res_popped_reg;
    logic             res_found_reg;
    bld_pkg::status_t res_status_reg;

    logic                         m_valid_reg;
    bld_pkg::value_t              out_popped_reg;
    logic                         out_found_reg;
    logic [bld_pkg::STATUS_W-1:0] out_status_reg;
    logic [bld_pkg::OCC_W-1:0]    out_occ_reg;

    bld_pkg::cnt_t  rd_lidx;
    bld_pkg::addr_t rd_addr;
    bld_pkg::addr_t head_dec;
    logic           wr_en;
    bld_pkg::addr_t wr_addr;
    bld_pkg::word_t wr_data;
    logic           out_free;

    assign head_dec = (head_reg == '0) ? bld_pkg::addr_t'(bld_pkg::CAPACITY - 1)
                                       : head_reg - bld_pkg::addr_t'(1);

    always_comb begin
        unique case (cmd_i.rd_sel)
            bld_pkg::RD_FRONT: rd_lidx = '0;
            bld_pkg::RD_BACK:  rd_lidx = count_reg - bld_pkg::cnt_t'(1);
            bld_pkg::RD_NEXT:  rd_lidx = cmp_idx_reg + bld_pkg::cnt_t'(1);
            default:           rd_lidx = '0;
        endcase
    end

    assign rd_addr = bld_pkg::wrap_add(head_reg, rd_lidx);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = bld_pkg::word_t'(value_reg);
        if (cmd_i.push) begin
            wr_en   = 1'b1;
            wr_addr = (kind_reg == bld_pkg::KIND_PUSH_FRONT) ? head_dec
                    : bld_pkg::wrap_add(head_reg, count_reg);
        end else if (cmd_i.shift_wr) begin
            // move entry cmp_idx one place toward the front
            wr_en   = 1'b1;
            wr_addr = bld_pkg::wrap_add(head_reg, cmp_idx_reg - bld_pkg::cnt_t'(1));
            wr_data = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        cmp_idx_next = cmp_idx_reg;
        if (cmd_i.push) begin
            count_next = count_reg + bld_pkg::cnt_t'(1);
            if (kind_reg == bld_pkg::KIND_PUSH_FRONT) head_next = head_dec;
        end
        if (cmd_i.pop) begin
            count_next = count_reg - bld_pkg::cnt_t'(1);
            if (kind_reg == bld_pkg::KIND_POP_FRONT) begin
                head_next = bld_pkg::wrap_add(head_reg, bld_pkg::cnt_t'(1));
            end
        end
        if (cmd_i.drop) begin
            count_next = count_reg - bld_pkg::cnt_t'(1);
        end
        if (cmd_i.scan_init) begin
            cmp_idx_next = '0;
        end else if (cmd_i.advance) begin
            cmp_idx_next = cmp_idx_reg + bld_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            cmp_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            cmp_idx_reg <= cmp_idx_next;
            if (cmd_i.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            kind_reg       <= in_kind;
            value_reg      <= in_value;
            res_popped_reg <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= bld_pkg::STAT_OK;
        end else begin
            if (cmd_i.take_pop)   res_popped_reg <= bld_pkg::value_t'(rdata_reg);
            if (cmd_i.set_found)  res_found_reg  <= 1'b1;
            if (cmd_i.set_status) res_status_reg <= cmd_i.status;
        end
        if (cmd_i.emit) begin
            out_popped_reg <= res_popped_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= bld_pkg::OCC_W'(count_reg);
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    assign stat_o.kind     = kind_reg;
    assign stat_o.empty    = (count_reg == '0);
    assign stat_o.full     = (count_reg == bld_pkg::cnt_t'(bld_pkg::CAPACITY));
    assign stat_o.match    = (rdata_reg == bld_pkg::word_t'(value_reg));
    assign stat_o.at_last  = (cmp_idx_reg == count_reg - bld_pkg::cnt_t'(1));
    assign stat_o.out_free = out_free;

    assign m_tvalid         = m_valid_reg;
    assign out_popped_value = out_popped_reg;
    assign out_found        = out_found_reg;
    assign out_status       = out_status_reg;
    assign out_occupancy    = out_occ_reg;

    `BLD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= bld_pkg::cnt_t'(bld_pkg::CAPACITY), "entry count above capacity")
    `BLD_ASSERT(a_push_room, aclk, aresetn, cmd_i.push |-> (count_reg != bld_pkg::cnt_t'(bld_pkg::CAPACITY)), "push into full list")
    `BLD_ASSERT(a_push_grows, aclk, aresetn, cmd_i.push |=> (count_reg == $past(count_reg) + bld_pkg::cnt_t'(1)), "push did not grow list")
    `BLD_ASSERT(a_shrink_nonempty, aclk, aresetn, (cmd_i.pop || cmd_i.drop) |-> (count_reg != '0), "entry removed from empty list")
    `BLD_ASSERT(a_emit_free, aclk, aresetn, cmd_i.emit |-> (!m_valid_reg || m_tready), "result overwritten before taken")
    `BLD_ASSERT_RST(a_reset_out, aclk, !aresetn |=> !m_valid_reg, "result valid after reset")

endmodule

`default_nettype wire

[hw/rtl/bounded_list_deque_with_search.sv]
`default_nettype none

// Bounded deque of up to 64 signed 32-bit entries kept as a circular buffer in one
// single-port-write, registered-read memory. Each request gives exactly one result.
// Query and remove walk the list from the front one entry per cycle through the
// memory read port, up to the match position or, when nothing matches, to the tail,
// and a remove then shifts every later entry forward one per cycle. One request is in
// flight at a time; the next request is taken as soon as the result sits in the output
// register, even if the sink has not yet taken it. Entries are not cleared at reset.
module bounded_list_deque_with_search (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] kind, [34:3] value, upper bits unused
    input  wire logic [bld_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] popped_value, [32] found, [34:33] status, [41:35] occupancy, upper bits zero
    output logic [bld_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    bld_pkg::dp_cmd_t  cmd;
    bld_pkg::dp_stat_t stat;

    bld_pkg::value_t                  popped_value;
    logic                             found;
    logic [bld_pkg::STATUS_W-1:0]     status;
    logic [bld_pkg::OCC_W-1:0]        occupancy;

    bld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    bld_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_i            (cmd),
        .stat_o           (stat),
        .in_kind          (s_tdata[bld_pkg::KIND_W-1:0]),
        .in_value         (s_tdata[bld_pkg::IN_FIELDS_W-1:bld_pkg::KIND_W]),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_popped_value (popped_value),
        .out_found        (found),
        .out_status       (status),
        .out_occupancy    (occupancy)
    );

    assign m_tdata = {(bld_pkg::OUT_TDATA_W - bld_pkg::OUT_FIELDS_W)'(0),
                      occupancy, status, found, popped_value};

endmodule

`default_nettype wire
